// File: design/stbc_pkg.sv
// ----------------------------------------------------------------------------
// stbc_pkg
// Shared types and constants for the software timer bank.
// ----------------------------------------------------------------------------
package stbc_pkg;

  localparam int unsigned REQ_W  = 2;
  localparam int unsigned ID_W   = 3;
  localparam int unsigned MS_W   = 16;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned MASK_W = 8;

  // Request codes carried on req_type
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 2'd0,
    REQ_START  = 2'd1,
    REQ_STOP   = 2'd2,
    REQ_RESUME = 2'd3
  } req_e;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_TICK = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  typedef logic [CNT_W-1:0] cnt_t;

endpackage

// File: design/software_timer_bank_core.sv
// Flow: stop and resume go straight to the response state; start waits on the
// divider (registered reciprocal-multiply divide by tick period); tick does
// one count-memory read-modify-write per slot, pipelined one slot per cycle.
// Throughput: one item at a time; the next item is taken once the current
// one has reached the output register, which may still wait on its receiver.
// Reset: asynchronous, all counts zero, all timers stopped, none timed out.
// ----------------------------------------------------------------------------
// software_timer_bank_core
// Bank of countdown timers with counts held in a synchronous memory and
// per-slot stopped / timed-out flags in flip-flops.
// ----------------------------------------------------------------------------
module software_timer_bank_core import stbc_pkg::*; #(
  parameter int unsigned NUM_TIMERS     = 8,
  parameter int unsigned TICK_PERIOD_MS = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [ID_W-1:0]   timer_id_i,
  input  logic [MS_W-1:0]   interval_ms_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [MASK_W-1:0] timed_out_mask_o,
  output logic [MASK_W-1:0] running_mask_o,
  output logic [MASK_W-1:0] expired_now_mask_o
);

  localparam int unsigned AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CW = $clog2(NUM_TIMERS + 1);
  localparam int unsigned PW = (NUM_TIMERS > MASK_W) ? NUM_TIMERS : MASK_W;
  localparam logic [CW-1:0] NUM_C  = CW'(NUM_TIMERS);
  localparam logic [CW-1:0] ONE_C  = CW'(1);
  localparam logic [6:0]    NUM_ID = 7'(NUM_TIMERS);

  state_e                state_q, state_d;
  logic [NUM_TIMERS-1:0] stopped_q, stopped_d;
  logic [NUM_TIMERS-1:0] tmo_q, tmo_d;
  logic [NUM_TIMERS-1:0] expired_q, expired_d;
  logic [CW-1:0]         rd_cnt_q, rd_cnt_d;
  logic                  pend_q;
  logic [AW-1:0]         pend_idx_q;
  logic [ID_W-1:0]       id_q, id_d;
  logic                  out_valid_q, out_valid_d;
  logic [MASK_W-1:0]     tmo_mask_q, run_mask_q, exp_mask_q;

  logic                  in_xfer, out_load, id_ok;
  logic                  rd_en, wr_en, div_start, div_done;
  logic [AW-1:0]         rd_addr, wr_addr;
  cnt_t                  wr_data, rd_data, quotient;
  logic [PW-1:0]         tmo_pad, run_pad, exp_pad;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign id_ok      = ({4'b0, timer_id_i} < NUM_ID);
  assign out_load   = (state_q == ST_RESP) && (!out_valid_q || !out_stall_i);

  assign rd_en     = (state_q == ST_TICK) && (rd_cnt_q != NUM_C);
  assign rd_addr   = rd_cnt_q[AW-1:0];
  assign div_start = in_xfer && (req_type_i == REQ_START) && id_ok;

  always_comb begin
    state_d     = state_q;
    stopped_d   = stopped_q;
    tmo_d       = tmo_q;
    expired_d   = expired_q;
    rd_cnt_d    = rd_cnt_q;
    id_d        = id_q;
    out_valid_d = out_valid_q;
    wr_en       = 1'b0;
    wr_addr     = pend_idx_q;
    wr_data     = rd_data - cnt_t'(1);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          id_d      = timer_id_i;
          expired_d = '0;
          case (req_type_i)
            REQ_TICK: begin
              rd_cnt_d = '0;
              state_d  = ST_TICK;
            end
            REQ_START: begin
              state_d = id_ok ? ST_DIV : ST_RESP;
            end
            REQ_STOP: begin
              if (id_ok) stopped_d[AW'(timer_id_i)] = 1'b1;
              state_d = ST_RESP;
            end
            REQ_RESUME: begin
              if (id_ok) stopped_d[AW'(timer_id_i)] = 1'b0;
              state_d = ST_RESP;
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_TICK: begin
        if (rd_en) begin
          rd_cnt_d = rd_cnt_q + ONE_C;
        end
        // count for pend_idx_q arrives now; reads run one slot ahead
        if (pend_q && !stopped_q[pend_idx_q]) begin
          if (rd_data != '0) begin
            wr_en = 1'b1;
          end else begin
            stopped_d[pend_idx_q] = 1'b1;
            tmo_d[pend_idx_q]     = 1'b1;
            expired_d[pend_idx_q] = 1'b1;
          end
        end
        if (!rd_en) begin
          state_d = ST_RESP;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          wr_en               = 1'b1;
          wr_addr             = AW'(id_q);
          wr_data             = quotient;
          stopped_d[AW'(id_q)] = 1'b0;
          tmo_d[AW'(id_q)]     = 1'b0;
          state_d             = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Only the first eight slots are shown; absent slots read as zero
  assign tmo_pad = PW'(tmo_q);
  assign run_pad = PW'(~stopped_q);
  assign exp_pad = PW'(expired_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stopped_q   <= '1;
      tmo_q       <= '0;
      expired_q   <= '0;
      rd_cnt_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stopped_q   <= stopped_d;
      tmo_q       <= tmo_d;
      expired_q   <= expired_d;
      rd_cnt_q    <= rd_cnt_d;
      pend_q      <= rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    pend_idx_q <= rd_addr;
    if (out_load) begin
      tmo_mask_q <= tmo_pad[MASK_W-1:0];
      run_mask_q <= run_pad[MASK_W-1:0];
      exp_mask_q <= exp_pad[MASK_W-1:0];
    end
  end

  stbc_cnt_ram #(
    .DEPTH (NUM_TIMERS),
    .AW    (AW)
  ) u_cnt_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  stbc_div #(
    .DIVISOR (TICK_PERIOD_MS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (interval_ms_i),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign out_valid_o        = out_valid_q;
  assign timed_out_mask_o   = tmo_mask_q;
  assign running_mask_o     = run_mask_q;
  assign expired_now_mask_o = exp_mask_q;

endmodule

// File: design/stbc_cnt_ram.sv
// ----------------------------------------------------------------------------
// stbc_cnt_ram
// Remaining-tick store: one write port, one read port, registered read data.
// Entries never written since reset read back as zero.
// ----------------------------------------------------------------------------
module stbc_cnt_ram import stbc_pkg::*; #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  cnt_t          wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output cnt_t          rd_data_o
);

  cnt_t             mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  cnt_t             rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem[rd_addr_i] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/stbc_div.sv
// ----------------------------------------------------------------------------
// stbc_div
// Divide by a fixed tick period through a constant reciprocal multiply; the
// quotient is registered and valid in the cycle after start.
// ----------------------------------------------------------------------------
module stbc_div import stbc_pkg::*; #(
  parameter int unsigned DIVISOR = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [MS_W-1:0] dividend_i,
  output logic            done_o,
  output cnt_t            quotient_o
);

  // Exact for every MS_W-bit dividend: reciprocal rounded up, scaled by
  // 2^(MS_W + ceil(log2 DIVISOR)), fits in MS_W + 1 bits.
  localparam int unsigned SHIFT_L  = $clog2(DIVISOR);
  localparam int unsigned SHIFT    = MS_W + SHIFT_L;
  localparam int unsigned RW       = MS_W + 1;
  localparam int unsigned PW       = MS_W + RW;
  localparam logic [63:0] RECIP_64 =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RW-1:0] RECIP  = RW'(RECIP_64);

  logic [PW-1:0] prod;
  cnt_t          quo_q;
  logic          done_q;

  assign prod = PW'(dividend_i) * PW'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= CNT_W'(prod >> SHIFT);
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: design/stbc_chk.sv
// ----------------------------------------------------------------------------
// stbc_chk
// Port-level checks for the software timer bank, bound to the top level.
// ----------------------------------------------------------------------------
module stbc_chk import stbc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [REQ_W-1:0]  req_type_i,
  input logic [ID_W-1:0]   timer_id_i,
  input logic [MS_W-1:0]   interval_ms_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [MASK_W-1:0] timed_out_mask_o,
  input logic [MASK_W-1:0] running_mask_o,
  input logic [MASK_W-1:0] expired_now_mask_o
);

  // a stalled request holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(req_type_i)
      && $stable(timer_id_i) && $stable(interval_ms_i))
    else $error("stalled request changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(timed_out_mask_o)
      && $stable(running_mask_o) && $stable(expired_now_mask_o))
    else $error("stalled result changed");

  // a timer that just expired is timed out
  a_exp_tmo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (expired_now_mask_o & ~timed_out_mask_o) == '0)
    else $error("expired timer not flagged timed out");

  // a timer that just expired is stopped
  a_exp_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (expired_now_mask_o & running_mask_o) == '0)
    else $error("expired timer still running");

  // after a transfer the bank is busy in the cycle that follows
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken back to back");

endmodule

bind software_timer_bank_core stbc_chk u_stbc_chk (.*);

// File: tb/tb_software_timer_bank_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_software_timer_bank_core
// Self-checking bench for the countdown timer bank. Requests go in through
// the valid/stall input channel. A bank model in the bench works out the
// three status masks for every accepted request. Each result transfer is
// compared with the oldest pending status. The run starts with directed
// request sequences and then sends weighted random traffic, first with
// random idling on both sides and then with none.
// ----------------------------------------------------------------------------
module tb_software_timer_bank_core;
  import stbc_pkg::*;

  localparam int unsigned BANK_SLOTS   = 8;
  localparam int unsigned BANK_TICK_MS = 1;

  typedef struct packed {
    logic [MASK_W-1:0] timed_out;
    logic [MASK_W-1:0] running;
    logic [MASK_W-1:0] expired_now;
  } bank_status_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [REQ_W-1:0]  req_type_i = '0;
  logic [ID_W-1:0]   timer_id_i = '0;
  logic [MS_W-1:0]   interval_ms_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [MASK_W-1:0] timed_out_mask_o;
  logic [MASK_W-1:0] running_mask_o;
  logic [MASK_W-1:0] expired_now_mask_o;

  // bank model state
  cnt_t ticks_left [BANK_SLOTS];
  logic is_stopped [BANK_SLOTS];
  logic has_timed_out [BANK_SLOTS];

  bank_status_t expected_status_q[$];
  bank_status_t due_status;
  int unsigned  error_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;

  software_timer_bank_core #(
    .NUM_TIMERS     (BANK_SLOTS),
    .TICK_PERIOD_MS (BANK_TICK_MS)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .timer_id_i         (timer_id_i),
    .interval_ms_i      (interval_ms_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .timed_out_mask_o   (timed_out_mask_o),
    .running_mask_o     (running_mask_o),
    .expired_now_mask_o (expired_now_mask_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  // Apply one request to the bank model and return the status it leaves.
  function automatic bank_status_t advance_timer_bank(req_e kind, logic [ID_W-1:0] id,
                                                      logic [MS_W-1:0] ms);
    bank_status_t st;
    st = '0;
    if (kind == REQ_TICK) begin
      for (int i = 0; i < BANK_SLOTS; i++) begin
        if (!is_stopped[i]) begin
          if (ticks_left[i] != '0) begin
            ticks_left[i] = ticks_left[i] - 1'b1;
          end else begin
            is_stopped[i] = 1'b1;
            has_timed_out[i] = 1'b1;
            if (i < MASK_W) st.expired_now[i] = 1'b1;
          end
        end
      end
    end else if (int'(id) < BANK_SLOTS) begin
      case (kind)
        REQ_START: begin
          ticks_left[id] = cnt_t'(32'(ms) / BANK_TICK_MS);
          has_timed_out[id] = 1'b0;
          is_stopped[id] = 1'b0;
        end
        REQ_STOP: is_stopped[id] = 1'b1;
        default: is_stopped[id] = 1'b0;
      endcase
    end
    for (int i = 0; i < BANK_SLOTS && i < MASK_W; i++) begin
      st.timed_out[i] = has_timed_out[i];
      st.running[i] = !is_stopped[i];
    end
    return st;
  endfunction

  // Drive one request, hold it until the transfer, then record its status.
  task automatic send_request(req_e kind, logic [ID_W-1:0] id, logic [MS_W-1:0] ms);
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    timer_id_i    <= id;
    interval_ms_i <= ms;
    do @(posedge clk_i); while (in_stall_o);
    expected_status_q.push_back(advance_timer_bank(kind, id, ms));
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  task automatic check_mask(string name, logic [MASK_W-1:0] want, logic [MASK_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %02h, actual %02h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_status_q.size() == 0) begin
        $error("result transfer with no pending request: %02h %02h %02h",
               timed_out_mask_o, running_mask_o, expired_now_mask_o);
        error_count++;
      end else begin
        due_status = expected_status_q.pop_front();
        check_mask("timed_out_mask", due_status.timed_out, timed_out_mask_o);
        check_mask("running_mask", due_status.running, running_mask_o);
        check_mask("expired_now_mask", due_status.expired_now, expired_now_mask_o);
      end
    end
  end

  // A bank fresh out of reset: everything stopped, a resumed zero count
  // expires on the first tick; ignored fields carry all zeros and all ones.
  task automatic test_idle_bank();
    send_request(REQ_TICK, 3'd0, 16'h0000);
    send_request(REQ_RESUME, 3'd3, 16'h0000);
    send_request(REQ_TICK, 3'd7, 16'hFFFF);
  endtask

  task automatic test_start_and_expiry();
    send_request(REQ_START, 3'd0, 16'h0000);
    send_request(REQ_START, 3'd7, 16'hFFFF);
    send_request(REQ_START, 3'd1, 16'd2);
    send_request(REQ_TICK, 3'd5, 16'h5A5A);
  endtask

  // Stop holds the count, resume picks it up where it was.
  task automatic test_stop_resume();
    send_request(REQ_STOP, 3'd1, 16'hFFFF);
    send_request(REQ_TICK, 3'd1, 16'h0000);
    send_request(REQ_RESUME, 3'd1, 16'hA5A5);
    repeat (3) send_request(REQ_TICK, 3'd0, 16'h0000);
    send_request(REQ_STOP, 3'd5, 16'h0000);
    send_request(REQ_RESUME, 3'd0, 16'h0000);
    send_request(REQ_TICK, 3'd2, 16'h0000);
  endtask

  task automatic test_restart_and_shared_expiry();
    send_request(REQ_START, 3'd7, 16'd1);
    send_request(REQ_START, 3'd3, 16'd1);
    repeat (2) send_request(REQ_TICK, 3'd4, 16'h0000);
    for (int i = 2; i < 7; i += 2) send_request(REQ_START, 3'(i), 16'h0000);
    send_request(REQ_START, 3'd5, 16'h0000);
    send_request(REQ_TICK, 3'd6, 16'hFFFF);
  endtask

  function automatic logic [MS_W-1:0] pick_interval();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return MS_W'($urandom_range(0, 6));
    if (roll < 85) return MS_W'($urandom_range(0, 40));
    if (roll < 95) return MS_W'($urandom);
    return (roll < 98) ? '1 : '0;
  endfunction

  // Ticks dominate and intervals are mostly short, so timers keep expiring.
  task automatic test_random_traffic(int unsigned count);
    int unsigned roll;
    req_e        kind;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 45)      kind = REQ_TICK;
      else if (roll < 75) kind = REQ_START;
      else if (roll < 87) kind = REQ_STOP;
      else                kind = REQ_RESUME;
      send_request(kind, ID_W'($urandom_range(0, 7)), pick_interval());
    end
  endtask

  initial begin
    for (int i = 0; i < BANK_SLOTS; i++) begin
      ticks_left[i] = '0;
      is_stopped[i] = 1'b1;
      has_timed_out[i] = 1'b0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 36;
    recv_idle_pct = 61;
    test_idle_bank();
    test_start_and_expiry();
    test_stop_resume();
    test_restart_and_shared_expiry();
    test_random_traffic(300);

    send_idle_pct = 61;
    recv_idle_pct = 36;
    test_random_traffic(300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(300);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    // catch any stray result after the last one
    repeat (BANK_SLOTS + 24) @(posedge clk_i);

    if (error_count == 0 && expected_status_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
